@@ sv/rfb_pkg.sv @@
// ----------------------------------------------------------------------------
// rfb_pkg: shared types, constants and pointer helpers for the ring FIFO
// Holds the queue geometry, the request and sequencer codes and the
// wrap-around pointer arithmetic used by the control unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rfb_pkg;

	// Queue geometry. One slot always stays empty, so DEPTH-1 are usable.
	localparam int DEPTH      = 64;
	localparam int ELEM_WIDTH = 32;

	// Field widths fixed by the interface.
	localparam int DATA_W = 32;
	localparam int CNT_W  = 6;

	// Stored word width: elements are masked to ELEM_WIDTH, beats carry 32 bits.
	localparam int STORE_W = (ELEM_WIDTH < DATA_W) ? ELEM_WIDTH : DATA_W;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_FILL  = 2'd1,
		REQ_READ  = 2'd2,
		REQ_FLUSH = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_EMIT
	} state_t;

	// Memory port request from the control unit.
	typedef struct packed {
		logic               we;
		logic [PTR_W-1:0]   waddr;
		logic [STORE_W-1:0] wdata;
		logic               re;
		logic [PTR_W-1:0]   raddr;
	} mem_req_t;

	// Result load request to the output register.
	typedef struct packed {
		logic             load;
		logic             has_data;
		logic [CNT_W-1:0] done_count;
		logic             last;
		logic [CNT_W-1:0] occupancy;
	} res_t;

	// Advance a pointer by one slot, wrapping at DEPTH.
	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] i);
		logic [PTR_W-1:0] r;
		begin
			if (i == PTR_W'(DEPTH - 1)) begin
				r = '0;
			end else begin
				r = i + PTR_W'(1);
			end
			return r;
		end
	endfunction

	// Number of stored elements for a head and tail pointer pair.
	function automatic logic [CNT_W-1:0] fifo_level(input logic [PTR_W-1:0] h,
			input logic [PTR_W-1:0] t);
		logic [PTR_W:0] d;
		begin
			if (t >= h) begin
				d = {1'b0, t} - {1'b0, h};
			end else begin
				d = (PTR_W+1)'(DEPTH) - ({1'b0, h} - {1'b0, t});
			end
			return CNT_W'(d);
		end
	endfunction

	function automatic logic [CNT_W-1:0] min_cnt(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

`default_nettype wire

@@ sv/rfb_ram.sv @@
// ----------------------------------------------------------------------------
// rfb_ram: single-write, single-read slot memory
// One write port and one read port with a registered read data output that
// holds its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module rfb_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 6,
	parameter int WORDS  = 64
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/rfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfb_ctrl: request sequencer and pointer unit
// Takes one request at a time and steps the head and tail pointers one slot
// at a time through the next_slot and fifo_level helpers from rfb_pkg.
// ----------------------------------------------------------------------------
`default_nettype none

module rfb_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   req_type,
	input  wire logic [rfb_pkg::DATA_W-1:0]   data_in,
	input  wire logic [rfb_pkg::CNT_W-1:0]    count,
	input  wire logic                         out_free,
	output rfb_pkg::mem_req_t                 mem_req,
	output rfb_pkg::res_t                     res
);

	rfb_pkg::state_t                  state_q, state_d;
	logic [rfb_pkg::PTR_W-1:0]        head_q, head_d;
	logic [rfb_pkg::PTR_W-1:0]        tail_q, tail_d;
	logic [rfb_pkg::CNT_W-1:0]        rem_q, rem_d;
	logic [rfb_pkg::CNT_W-1:0]        done_q, done_d;
	logic [rfb_pkg::STORE_W-1:0]      data_q, data_d;
	logic [rfb_pkg::CNT_W-1:0]        level;
	logic [rfb_pkg::CNT_W-1:0]        space;
	logic [rfb_pkg::CNT_W-1:0]        n;

	assign level = rfb_pkg::fifo_level(head_q, tail_q);
	assign space = rfb_pkg::CNT_W'(rfb_pkg::DEPTH - 1) - level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfb_pkg::ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			rem_q   <= '0;
			done_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			rem_q   <= rem_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		tail_d  = tail_q;
		rem_d   = rem_q;
		done_d  = done_q;
		data_d  = data_q;
		n       = '0;

		mem_req.we    = 1'b0;
		mem_req.waddr = tail_q;
		mem_req.wdata = data_q;
		mem_req.re    = 1'b0;
		mem_req.raddr = head_q;

		res            = '0;
		res.occupancy  = level;
		res.done_count = done_q;

		in_stall = (state_q != rfb_pkg::ST_IDLE);

		case (state_q)
			rfb_pkg::ST_IDLE: begin
				if (in_valid) begin
					data_d = rfb_pkg::STORE_W'(data_in);
					case (rfb_pkg::req_t'(req_type))
						rfb_pkg::REQ_WRITE: begin
							n       = rfb_pkg::min_cnt(rfb_pkg::CNT_W'(1), space);
							state_d = rfb_pkg::ST_FILL;
						end
						rfb_pkg::REQ_FILL: begin
							n       = rfb_pkg::min_cnt(count, space);
							state_d = rfb_pkg::ST_FILL;
						end
						rfb_pkg::REQ_READ: begin
							n = rfb_pkg::min_cnt(count, level);
							if (n == '0) begin
								state_d = rfb_pkg::ST_EMIT;
							end else begin
								state_d = rfb_pkg::ST_RD_ADDR;
							end
						end
						default: begin
							// Flush: stored words become unreachable once both
							// pointers return to the first slot.
							head_d  = '0;
							tail_d  = '0;
							state_d = rfb_pkg::ST_EMIT;
						end
					endcase
					rem_d  = n;
					done_d = n;
				end
			end
			rfb_pkg::ST_FILL: begin
				if (rem_q == '0) begin
					state_d = rfb_pkg::ST_EMIT;
				end else begin
					mem_req.we = 1'b1;
					tail_d     = rfb_pkg::next_slot(tail_q);
					rem_d      = rem_q - rfb_pkg::CNT_W'(1);
				end
			end
			rfb_pkg::ST_RD_ADDR: begin
				mem_req.re = 1'b1;
				head_d     = rfb_pkg::next_slot(head_q);
				state_d    = rfb_pkg::ST_RD_DATA;
			end
			rfb_pkg::ST_RD_DATA: begin
				if (out_free) begin
					res.load     = 1'b1;
					res.has_data = 1'b1;
					res.last     = (rem_q == rfb_pkg::CNT_W'(1));
					rem_d        = rem_q - rfb_pkg::CNT_W'(1);
					if (rem_q == rfb_pkg::CNT_W'(1)) begin
						state_d = rfb_pkg::ST_IDLE;
					end else begin
						state_d = rfb_pkg::ST_RD_ADDR;
					end
				end
			end
			rfb_pkg::ST_EMIT: begin
				if (out_free) begin
					res.load = 1'b1;
					res.last = 1'b1;
					state_d  = rfb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rfb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/ring_fifo_bulk_ops.sv @@
// Throughput: one request at a time, set by the sequencer in rfb_ctrl.
// A write or fill of n elements stores them slot by slot, then gives its result beat.
// A read of n elements gives one beat per element (address, then memory data).
// Flush and empty reads give their single beat from the emit state.
// Reset clears the pointers and sequencer at once; the memory needs no clearing.
// ----------------------------------------------------------------------------
// ring_fifo_bulk_ops: circular FIFO with bulk fill and bulk read requests
// Top level: sequencer, slot memory and the output register that holds a
// result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fifo_bulk_ops (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Request channel.
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   req_type,
	input  wire logic [rfb_pkg::DATA_W-1:0]   data_in,
	input  wire logic [rfb_pkg::CNT_W-1:0]    count,
	// Result channel.
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [rfb_pkg::DATA_W-1:0]   data_out,
	output logic                              has_data,
	output logic      [rfb_pkg::CNT_W-1:0]    done_count,
	output logic                              last,
	output logic      [rfb_pkg::CNT_W-1:0]    occupancy
);

	rfb_pkg::mem_req_t              mem_req;
	rfb_pkg::res_t                  res;
	logic [rfb_pkg::STORE_W-1:0]    rd_data;
	logic                           out_free;

	logic                           out_valid_q;
	logic [rfb_pkg::DATA_W-1:0]     data_out_q;
	logic                           has_data_q;
	logic [rfb_pkg::CNT_W-1:0]      done_count_q;
	logic                           last_q;
	logic [rfb_pkg::CNT_W-1:0]      occupancy_q;

	// The output register can take a new beat when it is empty or its
	// current beat leaves at this edge.
	assign out_free = !out_valid_q || !out_stall;

	rfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.data_in  (data_in),
		.count    (count),
		.out_free (out_free),
		.mem_req  (mem_req),
		.res      (res)
	);

	// Slot storage. Only slots written since the last flush are ever read,
	// so the memory starts without any clearing pass.
	rfb_ram #(
		.DATA_W (rfb_pkg::STORE_W),
		.ADDR_W (rfb_pkg::PTR_W),
		.WORDS  (rfb_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rd_data)
	);

	// Output beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat payload. Beats without a read element carry zero data.
	always_ff @(posedge clk) begin
		if (res.load) begin
			if (res.has_data) begin
				data_out_q <= rfb_pkg::DATA_W'(rd_data);
			end else begin
				data_out_q <= '0;
			end
			has_data_q   <= res.has_data;
			done_count_q <= res.done_count;
			last_q       <= res.last;
			occupancy_q  <= res.occupancy;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_out   = data_out_q;
	assign has_data   = has_data_q;
	assign done_count = done_count_q;
	assign last       = last_q;
	assign occupancy  = occupancy_q;

endmodule

`default_nettype wire
